@@ rtl/atb_pkg.sv @@
`default_nettype none

package atb_pkg;

   localparam int DEFAULT_MAX_LEN = 127;

   localparam int ACT_W   = 3;
   localparam int IDX_W   = 7;
   localparam int MARK_W  = 2;
   localparam int SYM_W   = 8;
   localparam int PAIR_W  = 9;
   localparam int SCORE_W = 16;

   localparam logic [ACT_W-1:0] ACT_LOAD_DIR    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_FIRST  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LOAD_SECOND = 3'd2;
   localparam logic [ACT_W-1:0] ACT_START       = 3'd3;
   localparam logic [ACT_W-1:0] ACT_STEP        = 3'd4;

   localparam logic [MARK_W-1:0] MARK_DIAG = 2'd0;
   localparam logic [MARK_W-1:0] MARK_UP   = 2'd1;
   localparam logic [MARK_W-1:0] MARK_LEFT = 2'd2;
   localparam logic [MARK_W-1:0] MARK_EDGE = 2'd3;

   localparam logic [PAIR_W-1:0] GAP = 9'd256;

   typedef struct packed {
      logic [ACT_W-1:0]          action;
      logic [IDX_W-1:0]          row_index;
      logic [IDX_W-1:0]          col_index;
      logic [MARK_W-1:0]         direction;
      logic [SYM_W-1:0]          symbol;
      logic signed [SCORE_W-1:0] end_score;
   } req_type;

   typedef struct packed {
      logic [PAIR_W-1:0]         top_symbol;
      logic [PAIR_W-1:0]         bottom_symbol;
      logic signed [SCORE_W-1:0] score;
      logic                      last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage

`default_nettype wire

@@ rtl/atb_ram.sv @@
`default_nettype none

module atb_ram
   import atb_pkg::*;
#(
   parameter int WIDTH  = SYM_W,
   parameter int DEPTH  = DEFAULT_MAX_LEN + 1,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/alignment_traceback.sv @@
// Load and start items are accepted while a result waits. A step item away from the
// origin reads the direction and both symbol memories, which have a synchronous read,
// at the accept edge; the read state then registers its pair, waiting while a result
// waits with rsp_ready low. No new item is accepted until the pair is registered.
// Reset (synchronous) clears position, edge mode, score, state and rsp_valid;
// memory contents are not cleared and hold whatever was last loaded.
`default_nettype none

module alignment_traceback
   import atb_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int DIM    = MAX_LEN + 1;
   localparam int POS_W  = $clog2(DIM);
   localparam int CELL_W = $clog2(DIM * DIM);
   localparam logic [CELL_W-1:0] DIM_C = CELL_W'(DIM);

   function automatic logic [CELL_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
      cell_addr = CELL_W'(CELL_W'(r) * DIM_C) + CELL_W'(c);
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(input logic [IDX_W-1:0] v);
      clamp_pos = (v > MAX_LEN) ? POS_W'(MAX_LEN) : POS_W'(v);
   endfunction

   state_type state_ff, state_in;
   logic [POS_W-1:0] row_pos_ff, row_pos_in;
   logic [POS_W-1:0] col_pos_ff, col_pos_in;
   logic edge_ff, edge_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept, finish, origin, row_nz, col_nz, mark_ok;
   logic dir_wr, first_wr, second_wr, mem_rd;
   logic [MARK_W-1:0] mark;
   logic [SYM_W-1:0] first_sym, second_sym;
   logic [POS_W-1:0] first_rd_addr, second_rd_addr, row_nx, col_nx;
   logic [PAIR_W-1:0] top_nx, bottom_nx;
   logic edge_nx;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign row_nz    = (row_pos_ff != '0);
   assign col_nz    = (col_pos_ff != '0);
   assign origin    = !row_nz && !col_nz;
   assign finish    = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_ready);

   assign dir_wr    = accept && (req_data.action == ACT_LOAD_DIR) &&
                      (req_data.row_index <= MAX_LEN) && (req_data.col_index <= MAX_LEN);
   assign first_wr  = accept && (req_data.action == ACT_LOAD_FIRST) &&
                      (req_data.row_index <= MAX_LEN);
   assign second_wr = accept && (req_data.action == ACT_LOAD_SECOND) &&
                      (req_data.col_index <= MAX_LEN);
   assign mem_rd    = accept && (req_data.action == ACT_STEP) && !origin;

   assign first_rd_addr  = row_nz ? row_pos_ff - POS_W'(1) : '0;
   assign second_rd_addr = col_nz ? col_pos_ff - POS_W'(1) : '0;

   atb_ram #(
      .WIDTH (MARK_W),
      .DEPTH (DIM * DIM)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr),
      .wr_addr (cell_addr(POS_W'(req_data.row_index), POS_W'(req_data.col_index))),
      .wr_data (req_data.direction),
      .rd_en   (mem_rd),
      .rd_addr (cell_addr(row_pos_ff, col_pos_ff)),
      .rd_data (mark)
   );

   atb_ram #(
      .WIDTH (SYM_W),
      .DEPTH (DIM)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (first_wr),
      .wr_addr (POS_W'(req_data.row_index)),
      .wr_data (req_data.symbol),
      .rd_en   (mem_rd),
      .rd_addr (first_rd_addr),
      .rd_data (first_sym)
   );

   atb_ram #(
      .WIDTH (SYM_W),
      .DEPTH (DIM)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (second_wr),
      .wr_addr (POS_W'(req_data.col_index)),
      .wr_data (req_data.symbol),
      .rd_en   (mem_rd),
      .rd_addr (second_rd_addr),
      .rd_data (second_sym)
   );

   assign mark_ok = ((mark == MARK_DIAG) && row_nz && col_nz) ||
                    ((mark == MARK_UP) && row_nz) ||
                    ((mark == MARK_LEFT) && col_nz);

   always_comb begin
      row_nx    = row_pos_ff;
      col_nx    = col_pos_ff;
      top_nx    = GAP;
      bottom_nx = GAP;
      edge_nx   = edge_ff;
      if (!edge_ff && mark_ok) begin
         case (mark)
            MARK_DIAG: begin
               top_nx    = {1'b0, first_sym};
               bottom_nx = {1'b0, second_sym};
               row_nx    = row_pos_ff - POS_W'(1);
               col_nx    = col_pos_ff - POS_W'(1);
            end
            MARK_UP: begin
               top_nx = {1'b0, first_sym};
               row_nx = row_pos_ff - POS_W'(1);
            end
            MARK_LEFT: begin
               bottom_nx = {1'b0, second_sym};
               col_nx    = col_pos_ff - POS_W'(1);
            end
            default: begin
            end
         endcase
      end else begin
         edge_nx = 1'b1;
         if (col_nz) begin
            bottom_nx = {1'b0, second_sym};
            col_nx    = col_pos_ff - POS_W'(1);
         end else begin
            top_nx = {1'b0, first_sym};
            row_nx = row_pos_ff - POS_W'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      edge_in      = edge_ff;
      score_in     = score_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.action == ACT_START)) begin
               row_pos_in = clamp_pos(req_data.row_index);
               col_pos_in = clamp_pos(req_data.col_index);
               score_in   = req_data.end_score;
               edge_in    = 1'b0;
            end
            if (mem_rd) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (finish) begin
               row_pos_in                = row_nx;
               col_pos_in                = col_nx;
               edge_in                   = edge_nx;
               rsp_valid_in              = 1'b1;
               rsp_data_in.top_symbol    = top_nx;
               rsp_data_in.bottom_symbol = bottom_nx;
               rsp_data_in.score         = score_ff;
               rsp_data_in.last          = (row_nx == '0) && (col_nx == '0);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         edge_ff      <= 1'b0;
         score_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         edge_ff      <= edge_in;
         score_ff     <= score_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_step_reads: assert property (@(posedge clock) disable iff (reset)
      mem_rd |=> (state_ff == ST_READ))
      else $error("step accepted away from origin did not enter read");

   a_read_not_origin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !origin)
      else $error("read state entered at origin cell");

   a_last_matches_pos: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && (rsp_data_ff.last == (row_pos_ff == '0 && col_pos_ff == '0))))
      else $error("last flag does not match updated position");
`endif

endmodule

`default_nettype wire
